>>> hdl/hfl_pkg.sv
// Package for the hash factorize labeler: sizes, payload and control types.
// No dependencies; used by every module under hdl.
package hfl_pkg;
	localparam int TABLE_ENTRIES = 4096;
	localparam int KEY_WIDTH = 64;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int QDEPTH = 2;

	localparam logic [2:0] REG_SKIP = 3'd0;
	localparam logic [2:0] REG_MASKED = 3'd1;
	localparam logic [2:0] REG_USE_KEY = 3'd2;
	localparam logic [2:0] REG_MKEY = 3'd3;
	localparam logic [2:0] REG_SENT = 3'd4;
	localparam logic [2:0] REG_FIRST = 3'd5;

	typedef struct packed {
		logic [63:0] key;
		logic missing_flag;
		logic last_item;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] label;
		logic is_new;
		logic table_full;
		logic last_result;
	} out_item_t;

	// request handed from front to back
	typedef struct packed {
		logic [KEY_WIDTH-1:0] key;
		logic missing;
		logic last_item;
	} req_t;

	typedef enum logic [2:0] {
		B_IDLE, B_HASH1, B_HASH2, B_READ, B_CHECK, B_CLEAR
	} bstate_t;
endpackage

>>> hdl/hfl_front.sv
// Front end: accepts items, classifies missing, and queues requests.
// Depends on hfl_pkg.
module hfl_front (
	input logic clk,
	input logic arst_n,
	input logic take,
	input hfl_pkg::in_item_t item,
	input logic masked_mode,
	input logic use_missing_key,
	input logic [63:0] missing_key,
	input logic pop,
	output logic q_valid,
	output logic q_full,
	output hfl_pkg::req_t q_head
);
	import hfl_pkg::*;
	req_t mem_q [QDEPTH];
	logic [0:0] wp_q, rp_q;
	logic [1:0] cnt_q;
	req_t r;

	always_comb begin
		r.key = item.key[KEY_WIDTH-1:0];
		r.last_item = item.last_item;
		if (masked_mode) r.missing = item.missing_flag;
		else r.missing = use_missing_key &&
			(item.key[KEY_WIDTH-1:0] == missing_key[KEY_WIDTH-1:0]);
	end

	always_ff @(posedge clk) begin
		if (take) mem_q[wp_q] <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (take) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {1'b0, take} - {1'b0, pop};
		end
	end

	assign q_valid = cnt_q != 2'd0;
	assign q_full = cnt_q == 2'(QDEPTH);
	assign q_head = mem_q[rp_q];
endmodule

>>> hdl/hfl_back.sv
// Back end: hashes, probes the open-addressed store, inserts new keys.
// Depends on hfl_pkg; clears the valid memory after reset.
module hfl_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input hfl_pkg::req_t q_head,
	input logic skip_missing,
	input logic [31:0] sentinel_label,
	input logic ld_first,
	input logic [30:0] first_val,
	output logic pop,
	output logic ready,
	output logic res_valid,
	output hfl_pkg::out_item_t res
);
	import hfl_pkg::*;
	logic [KEY_WIDTH-1:0] keys_mem [TABLE_ENTRIES];
	logic [31:0] labels_mem [TABLE_ENTRIES];
	logic valid_mem [TABLE_ENTRIES];

	bstate_t st_q, st_d;
	req_t cur_q;
	logic [63:0] mix_q;
	logic [IDX_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] n_q, n_d, count_q, clr_q;
	logic [31:0] next_q;
	logic [KEY_WIDTH-1:0] rkey_q;
	logic [31:0] rlab_q;
	logic rval_q;
	logic [63:0] h;
	logic wr_en, emit;
	out_item_t emit_d;

	assign h = mix_q ^ (mix_q >> 29);
	assign ready = st_q != B_CLEAR;

	always_comb begin
		st_d = st_q; pos_d = pos_q; n_d = n_q;
		pop = 1'b0; wr_en = 1'b0; emit = 1'b0;
		emit_d = '0;
		emit_d.last_result = cur_q.last_item;
		unique case (st_q)
			B_CLEAR: if (clr_q == CNT_W'(TABLE_ENTRIES - 1)) st_d = B_IDLE;
			B_IDLE: if (q_valid) begin
				pop = 1'b1; st_d = B_HASH1;
			end
			B_HASH1: begin
				if (skip_missing && cur_q.missing) begin
					emit = 1'b1;
					emit_d.label = sentinel_label;
					st_d = B_IDLE;
				end else st_d = B_HASH2;
			end
			B_HASH2: begin
				pos_d = h[IDX_W-1:0]; n_d = '0; st_d = B_READ;
			end
			B_READ: st_d = B_CHECK;
			B_CHECK: begin
				if (!rval_q || n_q == CNT_W'(TABLE_ENTRIES)) begin
					emit = 1'b1; st_d = B_IDLE;
					if (count_q == CNT_W'(TABLE_ENTRIES) || n_q == CNT_W'(TABLE_ENTRIES))
						emit_d.table_full = 1'b1;
					else begin
						wr_en = 1'b1;
						emit_d.label = next_q;
						emit_d.is_new = 1'b1;
					end
				end else if (rkey_q == cur_q.key) begin
					emit = 1'b1; emit_d.label = rlab_q; st_d = B_IDLE;
				end else begin
					pos_d = pos_q + 1'b1; n_d = n_q + 1'b1; st_d = B_READ;
				end
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_head;
		// shift-xor fold of the key; only picks where probing starts
		if (st_q == B_HASH1)
			mix_q <= 64'(cur_q.key) ^ (64'(cur_q.key) >> 23) ^ (64'(cur_q.key) >> 41);
		pos_q <= pos_d; n_q <= n_d;
		rkey_q <= keys_mem[pos_q];
		rlab_q <= labels_mem[pos_q];
		if (wr_en) begin
			keys_mem[pos_q] <= cur_q.key;
			labels_mem[pos_q] <= next_q;
		end
		res <= emit_d;
	end

	// valid bits: one write port shared by the clearing sweep and inserts
	always_ff @(posedge clk) begin
		rval_q <= valid_mem[pos_q];
		if (st_q == B_CLEAR) valid_mem[clr_q[IDX_W-1:0]] <= 1'b0;
		else if (wr_en) valid_mem[pos_q] <= 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_CLEAR; clr_q <= '0; count_q <= '0;
			next_q <= '0; res_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			res_valid <= emit;
			if (st_q == B_CLEAR) clr_q <= clr_q + 1'b1;
			if (wr_en) begin
				count_q <= count_q + 1'b1;
				next_q <= next_q + 32'd1;
			end
			if (ld_first) next_q <= {1'b0, first_val};
		end
	end
endmodule

>>> hdl/hash_factorize_labeler.sv
// Hash factorize labeler: dictionary encoder with dense labels.
// Each request goes through the HASH1, HASH2, READ and CHECK states; each extra
// probe repeats READ and CHECK. With skipping on, a missing item leaves HASH1 with
// the sentinel label. The back end takes one request at a time; busy rises while
// the request queue is full. Results can not be stalled.
// Reset clears registers, then a sweep clears all 4096 valid bits (busy high).
module hash_factorize_labeler (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input hfl_pkg::in_item_t in_item,
	output logic done,
	output hfl_pkg::out_item_t result,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data
);
	import hfl_pkg::*;
	logic skip_q, masked_q, usek_q;
	logic [63:0] mkey_q;
	logic [31:0] sent_q;
	logic q_valid, q_full, pop, bready, take;
	req_t q_head;

	assign busy = q_full || !bready;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b1; masked_q <= 1'b0; usek_q <= 1'b0;
			mkey_q <= '0; sent_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SKIP: skip_q <= cfg_data[0];
				REG_MASKED: masked_q <= cfg_data[0];
				REG_USE_KEY: usek_q <= cfg_data[0];
				REG_MKEY: mkey_q <= cfg_data;
				REG_SENT: sent_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	hfl_front u_front (
		.clk, .arst_n, .take, .item(in_item), .masked_mode(masked_q),
		.use_missing_key(usek_q), .missing_key(mkey_q), .pop,
		.q_valid, .q_full, .q_head
	);

	hfl_back u_back (
		.clk, .arst_n, .q_valid, .q_head, .skip_missing(skip_q),
		.sentinel_label(sent_q), .ld_first(cfg_we && cfg_index == REG_FIRST),
		.first_val(cfg_data[30:0]), .pop, .ready(bready),
		.res_valid(done), .res(result)
	);
endmodule

>>> hdl/hfl_checker.sv
// Port-level checks for the labeler; bound to the top level.
// Depends on hfl_pkg.
module hfl_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input hfl_pkg::out_item_t result
);
	a_new_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.is_new && result.table_full)) else $error("new and full");
	a_full_label: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.table_full |-> result.label == 0) else $error("full label");
	a_busy_reset: assert property (@(posedge clk) $rose(arst_n) |-> busy)
		else $error("clear sweep");
	a_no_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(done)) else $error("double result");
endmodule

bind hash_factorize_labeler hfl_checker u_chk (
	.clk, .arst_n, .start, .busy, .done, .result
);
